// ----- rtl/kdpe_pkg.sv -----
// Shared types, constants and helper functions for the key debounce event detector.
package kdpe_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int FILTER_MULT  = 2;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_MIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_MAX      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_MASK     = 3'd6;

  localparam logic [6:0]  FILTER_TIME_RST     = 7'd20;
  localparam logic [6:0]  TICK_STEP_RST       = 7'd1;
  localparam logic [15:0] LONG_PRESS_TIME_RST = 16'd1000;
  localparam logic [7:0]  REPEAT_PERIOD_RST   = 8'd0;
  localparam logic [15:0] DOUBLE_MIN_RST      = 16'd0;
  localparam logic [15:0] DOUBLE_MAX_RST      = 16'd300;
  localparam logic [3:0]  REPORT_MASK_RST     = 4'd3;

  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_LONG    = 2'd2;
  localparam logic [1:0] KIND_DOUBLE  = 2'd3;

  localparam logic [8:0]  CNT9_MAX  = 9'h1FF;
  localparam logic [15:0] CNT16_MAX = 16'hFFFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [6:0]  filter_time;
    logic [6:0]  tick_step;
    logic [15:0] long_press_time;
    logic [7:0]  repeat_period;
    logic [15:0] double_min;
    logic [15:0] double_max;
    logic [3:0]  report_mask;
  } cfg_t;

  typedef struct packed {
    logic [8:0]  filter_count;
    logic        debounced_pressed;
    logic [15:0] held_count;
    logic [8:0]  rep_count;
    logic [15:0] released_count;
  } key_state_t;

  typedef struct packed {
    logic [1:0] key;
    logic [1:0] kind;
    logic       last;
  } event_t;

  // Up to two events produced by one tick, in output order.
  typedef struct packed {
    logic [1:0] count;
    event_t     first;
    event_t     second;
  } event_pair_t;

  function automatic logic [8:0] sat_add9(input logic [8:0] a, input logic [6:0] b);
    logic [9:0] s;
    s = {1'b0, a} + {3'b000, b};
    return s[9] ? CNT9_MAX : s[8:0];
  endfunction

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [6:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {10'd0, b};
    return s[16] ? CNT16_MAX : s[15:0];
  endfunction

endpackage

// ----- rtl/kdpe_key_update.sv -----
// Per-key next-state and event logic for one tick sample.
module kdpe_key_update
  import kdpe_pkg::*;
(
  input  cfg_t        cfg,
  input  key_state_t  cur,
  input  logic [1:0]  key,
  input  logic        pressed,
  output key_state_t  nxt,
  output event_pair_t events
);

  logic [8:0]  f9;
  logic [8:0]  f2;
  logic [15:0] held_sum;
  logic [8:0]  rep_sum;
  logic [15:0] rel_base;
  logic        c0_v;
  logic        c1_v;
  logic [1:0]  c0_k;
  logic [1:0]  c1_k;

  assign f9 = {2'b00, cfg.filter_time};
  assign f2 = 9'(f9 * FILTER_MULT);
  assign held_sum = sat_add16(cur.held_count, cfg.tick_step);
  assign rep_sum  = sat_add9(cur.rep_count, cfg.tick_step);

  always_comb begin
    nxt      = cur;
    c0_v     = 1'b0;
    c1_v     = 1'b0;
    c0_k     = KIND_PRESS;
    c1_k     = KIND_PRESS;
    rel_base = cur.released_count;
    if (pressed) begin
      if (cur.filter_count < f9) begin
        nxt.filter_count = f9;
      end else if (cur.filter_count < f2) begin
        nxt.filter_count = sat_add9(cur.filter_count, cfg.tick_step);
      end else begin
        if (!cur.debounced_pressed) begin
          nxt.debounced_pressed = 1'b1;
          c0_v = cfg.report_mask[0];
          c0_k = KIND_PRESS;
        end
        if (cfg.long_press_time != 16'd0) begin
          if (cur.held_count < cfg.long_press_time) begin
            nxt.held_count = held_sum;
            c1_v = (held_sum == cfg.long_press_time) && cfg.report_mask[2];
            c1_k = KIND_LONG;
          end else if (cfg.repeat_period != 8'd0) begin
            // A repeat is reported as a press and is never masked.
            if (rep_sum >= {1'b0, cfg.repeat_period}) begin
              nxt.rep_count = 9'd0;
              c1_v = 1'b1;
            end else begin
              nxt.rep_count = rep_sum;
            end
            c1_k = KIND_PRESS;
          end
        end
      end
    end else begin
      if (cur.filter_count > f9) begin
        nxt.filter_count = f9;
      end else if (cur.filter_count != 9'd0) begin
        nxt.filter_count = (cur.filter_count > {2'b00, cfg.tick_step}) ?
                           cur.filter_count - {2'b00, cfg.tick_step} : 9'd0;
      end else begin
        if (cur.debounced_pressed) begin
          nxt.debounced_pressed = 1'b0;
          c0_v = cfg.report_mask[1];
          c0_k = KIND_RELEASE;
          c1_v = (cur.released_count > cfg.double_min) &&
                 (cur.released_count < cfg.double_max) && cfg.report_mask[3];
          c1_k = KIND_DOUBLE;
          rel_base = 16'd0;
        end
        nxt.released_count = sat_add16(rel_base, cfg.tick_step);
      end
      nxt.held_count = 16'd0;
      nxt.rep_count  = 9'd0;
    end
  end

  // Pack the candidates so the first valid one always leads.
  always_comb begin
    events.count       = {1'b0, c0_v} + {1'b0, c1_v};
    events.first.key   = key;
    events.first.kind  = c0_v ? c0_k : c1_k;
    events.first.last  = !(c0_v && c1_v);
    events.second.key  = key;
    events.second.kind = c1_k;
    events.second.last = 1'b1;
  end

endmodule

// ----- rtl/kdpe_event_fifo.sv -----
// Small event queue that takes up to two events per cycle and releases one while the reader is ready.
module kdpe_event_fifo
  import kdpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  event_pair_t push,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output event_t      head
);

  event_t                entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = entries[rd_ptr];
  // Space for a full pair, judged on the registered fill level.
  assign room      = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + FIFO_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end
  end

endmodule

// ----- rtl/key_debounce_press_event_detector_unit.sv -----
// Top level of the key debounce and press event detector.
//
// The input channel (in_valid/in_ready) carries one tick sample per beat:
// the key index and its raw level. A beat is registered first; once the queue
// has room, the per-key counters are read, updated and written back, and the
// zero, one or two events that the tick causes are written into a four-deep
// event queue. The output channel (out_valid/out_ready) delivers one event
// per beat, and last_event marks the final event of a tick.
// The events of a tick pass through the tick register and the event queue
// before they are offered on the output channel.
// A tick is accepted every cycle while the queue has room for two events;
// ticks that produce two events are limited by the single-event output port.
// When the receiver stalls, the queue fills and in_ready falls, but the
// registered tick is held safely and no event is ever dropped.
// Reset restores every configuration register to its default and puts every
// key in the released state with its filter count equal to the default
// filter time. Configuration is written through cfg_write/cfg_index/cfg_data
// while the block is idle; indexes beyond the register list are ignored.
module key_debounce_press_event_detector_unit
  import kdpe_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           key_index,
  input  logic                 pressed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           event_key,
  output logic [1:0]           event_kind,
  output logic                 last_event,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  cfg_t cfg;

  // Registered tick sample.
  logic       s1_valid;
  logic [1:0] s1_key;
  logic       s1_pressed;

  logic        s1_adv;
  logic        s1_in_range;
  logic [IDX_W-1:0] s1_idx;
  logic        room;

  key_state_t  cur;
  key_state_t  nxt;
  event_pair_t events;
  event_pair_t push;
  event_t      head;

  // Per-key state, one register per key and field.
  logic [8:0]  filter_count      [NUM_KEYS];
  logic        debounced_pressed [NUM_KEYS];
  logic [15:0] held_count        [NUM_KEYS];
  logic [8:0]  rep_count         [NUM_KEYS];
  logic [15:0] released_count    [NUM_KEYS];

  // Configuration registers. Each write keeps only the register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_time     <= FILTER_TIME_RST;
      cfg.tick_step       <= TICK_STEP_RST;
      cfg.long_press_time <= LONG_PRESS_TIME_RST;
      cfg.repeat_period   <= REPEAT_PERIOD_RST;
      cfg.double_min      <= DOUBLE_MIN_RST;
      cfg.double_max      <= DOUBLE_MAX_RST;
      cfg.report_mask     <= REPORT_MASK_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FILTER_TIME:     cfg.filter_time     <= cfg_data[6:0];
        REG_TICK_STEP:       cfg.tick_step       <= cfg_data[6:0];
        REG_LONG_PRESS_TIME: cfg.long_press_time <= cfg_data;
        REG_REPEAT_PERIOD:   cfg.repeat_period   <= cfg_data[7:0];
        REG_DOUBLE_MIN:      cfg.double_min      <= cfg_data;
        REG_DOUBLE_MAX:      cfg.double_max      <= cfg_data;
        REG_REPORT_MASK:     cfg.report_mask     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // The registered tick moves on once the queue can take both of its events.
  // Because the key state is written at that same edge, a following tick for
  // the same key always sees the updated counters.
  assign s1_adv   = s1_valid && room;
  assign in_ready = !s1_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_key     <= key_index;
      s1_pressed <= pressed;
    end
  end

  // Samples for keys that do not exist are dropped without effect.
  assign s1_in_range = ({30'd0, s1_key} < 32'(NUM_KEYS));
  assign s1_idx      = IDX_W'(s1_key);

  always_comb begin
    cur = '0;
    if (s1_in_range) begin
      cur.filter_count      = filter_count[s1_idx];
      cur.debounced_pressed = debounced_pressed[s1_idx];
      cur.held_count        = held_count[s1_idx];
      cur.rep_count         = rep_count[s1_idx];
      cur.released_count    = released_count[s1_idx];
    end
  end

  kdpe_key_update u_update (
    .cfg     (cfg),
    .cur     (cur),
    .key     (s1_key),
    .pressed (s1_pressed),
    .nxt     (nxt),
    .events  (events)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        filter_count[i]      <= {2'b00, FILTER_TIME_RST};
        debounced_pressed[i] <= 1'b0;
        held_count[i]        <= 16'd0;
        rep_count[i]         <= 9'd0;
        released_count[i]    <= 16'd0;
      end
    end else if (s1_adv && s1_in_range) begin
      filter_count[s1_idx]      <= nxt.filter_count;
      debounced_pressed[s1_idx] <= nxt.debounced_pressed;
      held_count[s1_idx]        <= nxt.held_count;
      rep_count[s1_idx]         <= nxt.rep_count;
      released_count[s1_idx]    <= nxt.released_count;
    end
  end

  always_comb begin
    push = events;
    if (!(s1_adv && s1_in_range)) begin
      push.count = 2'd0;
    end
  end

  kdpe_event_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign event_key  = head.key;
  assign event_kind = head.kind;
  assign last_event = head.last;

endmodule

// ----- tb/tb_key_debounce_press_event_detector_unit.sv -----
// Self-checking testbench for the key debounce and press event detector.
module tb_key_debounce_press_event_detector_unit;
  import kdpe_pkg::*;

  localparam int NUM_KEYS = NUM_KEYS_DEF;
  // Trailing cycles after the last expected event.
  localparam int DRAIN_CYCLES = 8;
  // Length of the single long receiver hold-off.
  localparam int HOLD_OFF_CYCLES = 300;
  // An index past the register list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // One tick sample as offered on the input channel.
  typedef struct {
    logic [1:0] key;
    logic       level;
  } tick_t;

  // One event as expected on the output channel.
  typedef struct {
    logic [1:0] key;
    logic [1:0] kind;
    logic       last;
  } key_event_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           key_index = '0;
  logic                 pressed = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           event_key;
  logic [1:0]           event_kind;
  logic                 last_event;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  key_debounce_press_event_detector_unit #(
    .NUM_KEYS(NUM_KEYS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .key_index (key_index),
    .pressed   (pressed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_key (event_key),
    .event_kind(event_kind),
    .last_event(last_event),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Ticks waiting to be offered, and events the block still owes us.
  tick_t      tick_queue[$];
  key_event_t expected_events[$];
  // Events raised by the tick being predicted, before the last one is marked.
  key_event_t tick_events[$];

  // Shadow copy of the configuration registers and of the per-key counters.
  cfg_t       cfg_model;
  logic [8:0]  filt_count   [NUM_KEYS];
  logic        deb_down     [NUM_KEYS];
  logic [15:0] held_count   [NUM_KEYS];
  logic [8:0]  rpt_count    [NUM_KEYS];
  logic [15:0] rel_count    [NUM_KEYS];
  // Raw level each key was last driven to, used to interleave other keys
  // into a run without disturbing their debounced state.
  logic        level_now    [NUM_KEYS];

  int         fail_count = 0;
  int         send_gap = 0;
  int         recv_gap = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  logic       no_idle = 1'b0;
  logic       stall_request = 1'b0;
  tick_t      next_tick;
  key_event_t want;

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard limit on the run, far beyond the slowest legal schedule.
  initial begin
    #20000000;
    $display("key_debounce_press_event_detector_unit test failed");
    $finish;
  end

  function automatic int saturate(input int value, input int limit);
    return (value > limit) ? limit : value;
  endfunction

  // Idle length between beats: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The block reports at most two events per tick; later ones are dropped.
  function automatic void note_event(input logic [1:0] k, input logic [1:0] kind);
    if (tick_events.size() < 2) tick_events.push_back('{key: k, kind: kind, last: 1'b0});
  endfunction

  task automatic reset_model();
    cfg_model = '{filter_time: FILTER_TIME_RST, tick_step: TICK_STEP_RST,
                  long_press_time: LONG_PRESS_TIME_RST, repeat_period: REPEAT_PERIOD_RST,
                  double_min: DOUBLE_MIN_RST, double_max: DOUBLE_MAX_RST,
                  report_mask: REPORT_MASK_RST};
    for (int i = 0; i < NUM_KEYS; i++) begin
      filt_count[i] = {2'b00, FILTER_TIME_RST};
      deb_down[i]   = 1'b0;
      held_count[i] = '0;
      rpt_count[i]  = '0;
      rel_count[i]  = '0;
      level_now[i]  = 1'b0;
    end
  endtask

  // Works out the events of one accepted tick and updates the shadow counters.
  task automatic predict_tick(input logic [1:0] k, input logic lvl);
    int f, t, fc, hc, rc, lc;
    if (k >= NUM_KEYS) return;
    f  = cfg_model.filter_time;
    t  = cfg_model.tick_step;
    fc = filt_count[k];
    hc = held_count[k];
    rc = rpt_count[k];
    lc = rel_count[k];
    if (lvl) begin
      // Pressed: the filter count climbs from F up to 2F before the key counts as down.
      if (fc < f) begin
        fc = f;
      end else if (fc < FILTER_MULT * f) begin
        fc = saturate(fc + t, CNT9_MAX);
      end else begin
        if (!deb_down[k]) begin
          deb_down[k] = 1'b1;
          if (cfg_model.report_mask[0]) note_event(k, KIND_PRESS);
        end
        if (cfg_model.long_press_time > 0) begin
          if (hc < cfg_model.long_press_time) begin
            // A step that jumps past the threshold gives no long event.
            hc = saturate(hc + t, CNT16_MAX);
            if (hc == cfg_model.long_press_time && cfg_model.report_mask[2])
              note_event(k, KIND_LONG);
          end else if (cfg_model.repeat_period > 0) begin
            // Repeats are reported as presses and ignore the mask.
            rc = saturate(rc + t, CNT9_MAX);
            if (rc >= cfg_model.repeat_period) begin
              rc = 0;
              note_event(k, KIND_PRESS);
            end
          end
        end
      end
    end else begin
      // Released: the filter count falls to F, then to zero without wrapping.
      if (fc > f) begin
        fc = f;
      end else if (fc != 0) begin
        fc = (fc > t) ? fc - t : 0;
      end else begin
        if (deb_down[k]) begin
          deb_down[k] = 1'b0;
          if (cfg_model.report_mask[1]) note_event(k, KIND_RELEASE);
          // The double click window is open at both ends.
          if (lc > cfg_model.double_min && lc < cfg_model.double_max &&
              cfg_model.report_mask[3])
            note_event(k, KIND_DOUBLE);
          lc = 0;
        end
        lc = saturate(lc + t, CNT16_MAX);
      end
      hc = 0;
      rc = 0;
    end
    filt_count[k] = 9'(fc);
    held_count[k] = 16'(hc);
    rpt_count[k]  = 9'(rc);
    rel_count[k]  = 16'(lc);
    if (tick_events.size() > 0) begin
      tick_events[tick_events.size() - 1].last = 1'b1;
      foreach (tick_events[i]) expected_events.push_back(tick_events[i]);
      tick_events.delete();
    end
  endtask

  // Register write; the block is idle whenever this is called.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_FILTER_TIME:     cfg_model.filter_time     = value[6:0];
      REG_TICK_STEP:       cfg_model.tick_step       = value[6:0];
      REG_LONG_PRESS_TIME: cfg_model.long_press_time = value;
      REG_REPEAT_PERIOD:   cfg_model.repeat_period   = value[7:0];
      REG_DOUBLE_MIN:      cfg_model.double_min      = value;
      REG_DOUBLE_MAX:      cfg_model.double_max      = value;
      REG_REPORT_MASK:     cfg_model.report_mask     = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int f, input int t, input int lpt, input int rp,
                            input int dmin, input int dmax, input int mask);
    write_reg(REG_FILTER_TIME, CFG_W'(f));
    write_reg(REG_TICK_STEP, CFG_W'(t));
    write_reg(REG_LONG_PRESS_TIME, CFG_W'(lpt));
    write_reg(REG_REPEAT_PERIOD, CFG_W'(rp));
    write_reg(REG_DOUBLE_MIN, CFG_W'(dmin));
    write_reg(REG_DOUBLE_MAX, CFG_W'(dmax));
    write_reg(REG_REPORT_MASK, CFG_W'(mask));
  endtask

  task automatic queue_run(input logic [1:0] k, input logic lvl, input int count);
    level_now[k] = lvl;
    repeat (count) tick_queue.push_back('{key: k, level: lvl});
  endtask

  // Random key activity built from runs of one level on one key. Most runs are
  // long enough to get through the filter, some go on into long press and
  // repeat, and a few are short bounces. Other keys are slipped in at their
  // current level so that several keys are in flight at once.
  task automatic queue_random_ticks(input int count);
    int added, run_len, deb_len, hold_len, r;
    logic [1:0] k, other;
    logic lvl;
    added = 0;
    while (added < count) begin
      k   = 2'($urandom_range(0, NUM_KEYS - 1));
      lvl = 1'($urandom_range(0, 1));
      deb_len  = FILTER_MULT * cfg_model.filter_time / cfg_model.tick_step + 3;
      hold_len = cfg_model.long_press_time / cfg_model.tick_step
               + 2 * cfg_model.repeat_period / cfg_model.tick_step + 4;
      if (hold_len > 700) hold_len = 700;
      r = $urandom_range(0, 99);
      if (r < 15) run_len = $urandom_range(1, 3);
      else if (r < 75) run_len = $urandom_range(deb_len / 2 + 1, deb_len + 6);
      else run_len = $urandom_range(deb_len, deb_len + hold_len);
      level_now[k] = lvl;
      for (int i = 0; i < run_len && added < count; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          other = 2'($urandom_range(0, NUM_KEYS - 1));
          tick_queue.push_back('{key: other, level: level_now[other]});
        end else begin
          tick_queue.push_back('{key: k, level: lvl});
        end
        added++;
      end
    end
  endtask

  // Holds the sender back until every tick is in and every event is out.
  // The check runs on the falling edge, after all rising-edge updates settle.
  task automatic wait_idle();
    while (tick_queue.size() != 0 || in_valid || expected_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: offers queued ticks, with a random gap after each beat.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        next_tick = tick_queue.pop_front();
        in_valid  <= 1'b1;
        key_index <= next_tick.key;
        pressed   <= next_tick.level;
        send_gap  = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that lets the event
  // queue fill so the input channel has to back up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) recv_gap = pick_gap();
      out_ready <= (recv_gap == 0);
    end
  end

  // Monitor: predicts on every accepted tick first, then checks every
  // accepted event against the oldest one still expected.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_tick(key_index, pressed);
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event: key %0d kind %0d last %0d",
                 event_key, event_kind, last_event);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (event_key !== want.key) begin
            $error("event_key mismatch: expected %0d, actual %0d", want.key, event_key);
            fail_count++;
          end
          if (event_kind !== want.kind) begin
            $error("event_kind mismatch: expected %0d, actual %0d", want.kind, event_kind);
            fail_count++;
          end
          if (last_event !== want.last) begin
            $error("last_event mismatch: expected %0d, actual %0d", want.last, last_event);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: slow filter, long press out of reach, press and release only.
    queue_random_ticks(100);
    wait_idle();

    // Directed: with a one-tick filter every kind of event shows up within a
    // few samples. Key 0 goes through press, long press, two repeats, then
    // release. Key 3 may still hold a filter count above the new 2F, in which
    // case it is pressed at once.
    set_config(1, 1, 2, 1, 0, 100, 15);
    queue_run(0, 1'b0, 3);
    queue_run(0, 1'b1, 6);
    queue_run(0, 1'b0, 3);
    queue_run(3, 1'b1, 2);
    queue_run(3, 1'b0, 3);
    queue_run(1, 1'b1, 1);
    queue_run(2, 1'b0, 1);
    wait_idle();

    // Busy traffic at full rate on both sides, with the long receiver hold-off.
    set_config(1, 1, 3, 2, 1, 20, 15);
    no_idle       <= 1'b1;
    stall_request <= 1'b1;
    queue_random_ticks(150);
    wait_idle();
    no_idle <= 1'b0;

    // Largest filter and step. Held time saturates at the top of its range
    // and still meets a long press threshold of all ones. A long released
    // stretch on key 2 saturates its released time, which must then lie
    // outside the double click window rather than wrap into it.
    set_config(127, 127, 65535, 255, 0, 65535, 12);
    queue_random_ticks(100);
    queue_run(2, 1'b0, 540);
    queue_run(2, 1'b1, 3);
    queue_run(2, 1'b0, 3);
    wait_idle();

    // Step that overshoots the long press threshold: no long event, repeats
    // start at once. A write to an index past the register list comes first.
    write_reg(REG_UNUSED, 16'hFFFF);
    set_config(5, 3, 10, 7, 2, 60, 13);
    queue_random_ticks(80);
    wait_idle();

    // Long press and repeat disabled, empty double click window.
    set_config(3, 2, 0, 4, 0, 0, 15);
    queue_random_ticks(80);
    wait_idle();

    // Repeat disabled, both double click window bounds at their maximum.
    set_config(2, 1, 4, 0, 65535, 65535, 6);
    queue_random_ticks(60);
    wait_idle();

    if (fail_count == 0) begin
      $display("key_debounce_press_event_detector_unit test passed");
    end else begin
      $display("key_debounce_press_event_detector_unit test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/kdpe_pkg.sv
rtl/kdpe_key_update.sv
rtl/kdpe_event_fifo.sv
rtl/key_debounce_press_event_detector_unit.sv
tb/tb_key_debounce_press_event_detector_unit.sv
